// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the top-level RTL file.
// Each expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/eadsr_pkg.sv =====
`default_nettype none

package eadsr_pkg;

    // Fixed-point format: 1.0 = 2^FRAC_BITS
    localparam int FRAC_BITS = 24;

    localparam int LVL_W      = FRAC_BITS + 1;
    localparam int COEF_W     = FRAC_BITS;
    localparam int TGT_W      = FRAC_BITS + 2;
    localparam int PH_W       = 3;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TGT_W;

    localparam logic [LVL_W-1:0] ONE     = LVL_W'(64'd1 << FRAC_BITS);
    // Release ends at or below 1% of full scale
    localparam logic [LVL_W-1:0] REL_THR = LVL_W'((64'd1 << FRAC_BITS) / 64'd100);

    // Reciprocal of 100 for the decay end threshold: x/100 = (x*RECIP) >> RECIP_SH
    localparam int RECIP_SH = FRAC_BITS + 8;
    localparam int RECIP_W  = FRAC_BITS + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) / 64'd100) + 64'd1);

    // Register reset values
    localparam logic [COEF_W-1:0] COEF_RST    = COEF_W'(64'd16700000);
    localparam logic [LVL_W-1:0]  SUSTAIN_RST = LVL_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [TGT_W-1:0]  TARGET_RST  = TGT_W'(64'd20132659);
    localparam logic [LVL_W-1:0]  DEC_THR_RST =
        LVL_W'(((64'd1 << FRAC_BITS) - (64'd1 << (FRAC_BITS - 1))) / 64'd100);

    // Envelope stages
    localparam logic [PH_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PH_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PH_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PH_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PH_W-1:0] PH_RELEASE = 3'd4;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MOD      = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_MODE     = 3'd5;

    typedef struct packed {
        logic [COEF_W-1:0] attack_coef;
        logic [COEF_W-1:0] decay_coef;
        logic [COEF_W-1:0] release_coef;
        logic [LVL_W-1:0]  sustain;
        logic [TGT_W-1:0]  target;
        logic              lfo_mode;
        logic [LVL_W-1:0]  dec_thr;
        logic              dec_thr_en;
    } eadsr_cfg_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [PH_W-1:0]  phase;
        logic             key_held;
        logic             mod_seen;
        logic             gate_on;
    } eadsr_state_t;

endpackage

`default_nettype wire

// ===== rtl/eadsr_cmd_if.sv =====
`default_nettype none

interface eadsr_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [eadsr_pkg::CMD_W-1:0] cmd;
    logic                        retrigger;
    logic                        mod_level;

    modport source (output valid, output cmd, output retrigger, output mod_level,
                    input ready);
    modport sink (input valid, input cmd, input retrigger, input mod_level,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/eadsr_env_if.sv =====
`default_nettype none

interface eadsr_env_if;
    logic                        valid;
    logic                        ready;
    logic [eadsr_pkg::LVL_W-1:0] level;
    logic [eadsr_pkg::PH_W-1:0]  phase;

    modport source (output valid, output level, output phase, input ready);
    modport sink (input valid, input level, input phase, output ready);
endinterface

`default_nettype wire

// ===== rtl/eadsr_cfg.sv =====
`default_nettype none

module eadsr_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [eadsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [eadsr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output eadsr_pkg::eadsr_cfg_t                    cfg
);

    logic [eadsr_pkg::COEF_W-1:0] attack_coef_reg;
    logic [eadsr_pkg::COEF_W-1:0] decay_coef_reg;
    logic [eadsr_pkg::COEF_W-1:0] release_coef_reg;
    logic [eadsr_pkg::LVL_W-1:0]  sustain_reg;
    logic [eadsr_pkg::TGT_W-1:0]  target_reg;
    logic                         lfo_mode_reg;
    logic [eadsr_pkg::LVL_W-1:0]  dec_thr_reg;
    logic                         dec_thr_en_reg;

    logic [eadsr_pkg::LVL_W-1:0]                      sus_wr;
    logic [eadsr_pkg::LVL_W-1:0]                      excursion;
    logic [eadsr_pkg::LVL_W+eadsr_pkg::RECIP_W-1:0]   thr_prod;
    logic [eadsr_pkg::LVL_W-1:0]                      dec_thr_next;
    logic                                             dec_thr_en_next;

    // Precompute the decay end threshold (1.0 - sustain) / 100 from the written value
    assign sus_wr          = cfg_wdata[eadsr_pkg::LVL_W-1:0];
    assign excursion       = eadsr_pkg::ONE - sus_wr;
    assign thr_prod        = excursion * eadsr_pkg::RECIP;
    assign dec_thr_next    = eadsr_pkg::LVL_W'(thr_prod >> eadsr_pkg::RECIP_SH);
    assign dec_thr_en_next = (sus_wr <= eadsr_pkg::ONE);

    // Hold register values; update the addressed one on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coef_reg  <= eadsr_pkg::COEF_RST;
            decay_coef_reg   <= eadsr_pkg::COEF_RST;
            release_coef_reg <= eadsr_pkg::COEF_RST;
            sustain_reg      <= eadsr_pkg::SUSTAIN_RST;
            target_reg       <= eadsr_pkg::TARGET_RST;
            lfo_mode_reg     <= 1'b0;
            dec_thr_reg      <= eadsr_pkg::DEC_THR_RST;
            dec_thr_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eadsr_pkg::CFG_ATTACK_COEF:
                    attack_coef_reg <= cfg_wdata[eadsr_pkg::COEF_W-1:0];
                eadsr_pkg::CFG_DECAY_COEF:
                    decay_coef_reg <= cfg_wdata[eadsr_pkg::COEF_W-1:0];
                eadsr_pkg::CFG_RELEASE_COEF:
                    release_coef_reg <= cfg_wdata[eadsr_pkg::COEF_W-1:0];
                eadsr_pkg::CFG_SUSTAIN:
                begin
                    sustain_reg    <= sus_wr;
                    dec_thr_reg    <= dec_thr_next;
                    dec_thr_en_reg <= dec_thr_en_next;
                end
                eadsr_pkg::CFG_TARGET:
                    target_reg <= cfg_wdata;
                eadsr_pkg::CFG_LFO_MODE:
                    lfo_mode_reg <= cfg_wdata[0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        cfg.attack_coef  = attack_coef_reg;
        cfg.decay_coef   = decay_coef_reg;
        cfg.release_coef = release_coef_reg;
        cfg.sustain      = sustain_reg;
        cfg.target       = target_reg;
        cfg.lfo_mode     = lfo_mode_reg;
        cfg.dec_thr      = dec_thr_reg;
        cfg.dec_thr_en   = dec_thr_en_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/eadsr_step.sv =====
`default_nettype none

module eadsr_step (
    input  eadsr_pkg::eadsr_state_t              cur,
    input  wire logic [eadsr_pkg::CMD_W-1:0]     cmd,
    input  wire logic                            retrigger,
    input  wire logic                            mod_level,
    input  eadsr_pkg::eadsr_cfg_t                cfg,
    output eadsr_pkg::eadsr_state_t              nxt
);

    localparam int F     = eadsr_pkg::FRAC_BITS;
    localparam int TGT_W = eadsr_pkg::TGT_W;
    localparam int LVL_W = eadsr_pkg::LVL_W;
    localparam int PRD_W = eadsr_pkg::TGT_W + eadsr_pkg::COEF_W;

    logic                          gate_eff;
    logic [eadsr_pkg::PH_W-1:0]    ph_g;
    logic                          gate_g;
    logic [TGT_W-1:0]              lvl_ext;
    logic [TGT_W-1:0]              sus_ext;
    logic                          tgt_above;
    logic [TGT_W-1:0]              mul_a;
    logic [eadsr_pkg::COEF_W-1:0]  mul_coef;
    logic [PRD_W-1:0]              prod;
    logic [TGT_W-1:0]              step_s;
    logic [TGT_W:0]                atk_nv;

    // In trigger mode, edges of key AND modulator start attack or release on a tick
    always_comb
    begin
        gate_eff = cur.key_held & cur.mod_seen;
        ph_g     = cur.phase;
        gate_g   = cur.gate_on;
        if (cfg.lfo_mode)
        begin
            if (gate_eff && !cur.gate_on)
            begin
                gate_g = 1'b1;
                ph_g   = eadsr_pkg::PH_ATTACK;
            end
            else if (!gate_eff && cur.gate_on)
            begin
                gate_g = 1'b0;
                if (cur.phase != eadsr_pkg::PH_IDLE)
                    ph_g = eadsr_pkg::PH_RELEASE;
            end
        end
    end

    // Select the operands of the shared stage multiplier
    assign lvl_ext   = {1'b0, cur.level};
    assign sus_ext   = {1'b0, cfg.sustain};
    assign tgt_above = (cfg.target > lvl_ext);

    always_comb
    begin
        case (ph_g)
            eadsr_pkg::PH_ATTACK:
            begin
                mul_a    = tgt_above ? (cfg.target - lvl_ext) : (lvl_ext - cfg.target);
                mul_coef = cfg.attack_coef;
            end
            eadsr_pkg::PH_DECAY:
            begin
                mul_a    = lvl_ext - sus_ext;
                mul_coef = cfg.decay_coef;
            end
            default:
            begin
                mul_a    = lvl_ext;
                mul_coef = cfg.release_coef;
            end
        endcase
    end

    assign prod   = mul_a * mul_coef;
    assign step_s = prod[TGT_W+F-1:F];
    assign atk_nv = tgt_above ? ({1'b0, cfg.target} - {1'b0, step_s})
                              : ({1'b0, cfg.target} + {1'b0, step_s});

    // Apply the command to the state
    always_comb
    begin
        nxt = cur;
        case (cmd)
            eadsr_pkg::CMD_TICK:
            begin
                nxt.gate_on = gate_g;
                nxt.phase   = ph_g;
                case (ph_g)
                    eadsr_pkg::PH_ATTACK:
                    begin
                        if (atk_nv >= (TGT_W+1)'(eadsr_pkg::ONE) || cfg.attack_coef == '0)
                        begin
                            nxt.level = eadsr_pkg::ONE;
                            nxt.phase = eadsr_pkg::PH_DECAY;
                        end
                        else
                            nxt.level = atk_nv[LVL_W-1:0];
                    end
                    eadsr_pkg::PH_DECAY:
                    begin
                        if (cur.level <= cfg.sustain)
                        begin
                            nxt.level = cfg.sustain;
                            nxt.phase = eadsr_pkg::PH_SUSTAIN;
                        end
                        else if (cfg.dec_thr_en && step_s <= TGT_W'(cfg.dec_thr))
                        begin
                            nxt.level = cfg.sustain;
                            nxt.phase = eadsr_pkg::PH_SUSTAIN;
                        end
                        else
                            nxt.level = cfg.sustain + step_s[LVL_W-1:0];
                    end
                    eadsr_pkg::PH_SUSTAIN:
                        nxt.level = cfg.sustain;
                    eadsr_pkg::PH_RELEASE:
                    begin
                        if (step_s <= TGT_W'(eadsr_pkg::REL_THR) || cfg.release_coef == '0)
                        begin
                            nxt.level = '0;
                            nxt.phase = eadsr_pkg::PH_IDLE;
                        end
                        else
                            nxt.level = step_s[LVL_W-1:0];
                    end
                    default:
                    begin
                        nxt.level = '0;
                        nxt.phase = eadsr_pkg::PH_IDLE;
                    end
                endcase
            end
            eadsr_pkg::CMD_NOTE_ON:
            begin
                nxt.key_held = 1'b1;
                if (cfg.lfo_mode)
                    nxt.gate_on = 1'b0;
                else
                begin
                    nxt.gate_on = 1'b1;
                    if (retrigger ||
                        cur.phase inside {eadsr_pkg::PH_IDLE, eadsr_pkg::PH_RELEASE})
                        nxt.phase = eadsr_pkg::PH_ATTACK;
                end
            end
            eadsr_pkg::CMD_NOTE_OFF:
            begin
                nxt.key_held = 1'b0;
                if (!cfg.lfo_mode)
                begin
                    nxt.gate_on = 1'b0;
                    if (cur.phase != eadsr_pkg::PH_IDLE)
                        nxt.phase = eadsr_pkg::PH_RELEASE;
                end
            end
            default:
                nxt.mod_seen = mod_level;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/exponential_adsr_envelope_unit.sv =====
// Channel   Modport  Payload                         Role
// cmd_ch    sink     cmd, retrigger, mod_level       command requests in
// env_ch    source   level, phase                    envelope results out
// cfg_*     plain    cfg_we, cfg_index, cfg_wdata    register writes
//
// One request per cycle sustained while env_ch.ready holds; each request is
// accepted into the input register, then passes through the shared 26x24 stage
// multiplier and is loaded into the result register.
// Reset (rst_n low, asynchronous) clears state to idle with level zero and
// loads the register defaults; there is no clearing pass.
// A stalled result holds in the output register while one more request waits
// in the input register; cmd_ch.ready drops only when both are full.
`default_nettype none
`include "assert_macros.svh"

module exponential_adsr_envelope_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    eadsr_cmd_if.sink                             cmd_ch,
    eadsr_env_if.source                           env_ch,
    input  wire logic                             cfg_we,
    input  wire logic [eadsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [eadsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    eadsr_pkg::eadsr_cfg_t        cfg;
    eadsr_pkg::eadsr_state_t      state_reg;
    eadsr_pkg::eadsr_state_t      state_next;

    logic                         in_valid_reg;
    logic [eadsr_pkg::CMD_W-1:0]  cmd_reg;
    logic                         retrig_reg;
    logic                         mod_reg;

    logic                         out_valid_reg;
    logic [eadsr_pkg::LVL_W-1:0]  level_reg;
    logic [eadsr_pkg::PH_W-1:0]   phase_reg;

    logic                         out_free;
    logic                         advance;
    logic                         in_take;

    eadsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    eadsr_step u_step (
        .cur       (state_reg),
        .cmd       (cmd_reg),
        .retrigger (retrig_reg),
        .mod_level (mod_reg),
        .cfg       (cfg),
        .nxt       (state_next)
    );

    // Handshake: advance the input stage when the result register can take it
    assign out_free     = !out_valid_reg || env_ch.ready;
    assign advance      = in_valid_reg && out_free;
    assign cmd_ch.ready = !in_valid_reg || advance;
    assign in_take      = cmd_ch.valid && cmd_ch.ready;

    // Capture the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd_ch.ready)
            in_valid_reg <= cmd_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= cmd_ch.cmd;
            retrig_reg <= cmd_ch.retrigger;
            mod_reg    <= cmd_ch.mod_level;
        end
    end

    // Commit the envelope state for each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.level    <= '0;
            state_reg.phase    <= eadsr_pkg::PH_IDLE;
            state_reg.key_held <= 1'b0;
            state_reg.mod_seen <= 1'b0;
            state_reg.gate_on  <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg <= state_next.level;
            phase_reg <= state_next.phase;
        end
    end

    assign env_ch.valid = out_valid_reg;
    assign env_ch.level = level_reg;
    assign env_ch.phase = phase_reg;

    // Idle always carries a zero level
    `ASSERT_IMPLIES(a_idle_level_zero, state_reg.phase == eadsr_pkg::PH_IDLE,
        state_reg.level == '0)
    // A processed request always lands in the result register
    `ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    // A request blocked by a full result register stays in the input stage
    `ASSERT_NEXT(a_blocked_request_holds, in_valid_reg && !out_free, in_valid_reg)

endmodule

`default_nettype wire
